/* rtl/mlpq_pkg.sv */
// Package for the multilevel priority queue.
// Holds the controller state type, the result status codes and the fixed field widths.
// Depends on nothing; every module of the block imports it.
package mlpq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 5;
    localparam int TDATA_W = 40;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_READ
    } mlpq_state_t;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_REMOVED  = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_EMPTY    = 2'd3
    } mlpq_status_t;

endpackage

/* rtl/multilevel_priority_queue.sv */
// Top level of the multilevel priority queue: handshake, control sequencer and level mask.
// Instantiates mlpq_level_mem and mlpq_entry_mem; uses mlpq_pkg.
//
//   Channel | Direction | tdata (low bit up)               | tuser
//   s_      | in        | value_in[31:0], priority_in[4:0] | mode
//   m_      | out       | value_out[31:0], priority_out[4:0] | status
//
// An insert runs through a level table read and then its write-back with the ring access;
// a remove adds a registered word read after the write-back.
// A remove with every level empty stays in idle; its result is loaded at the accepting edge.
// Reset leaves every level empty; no memory sweep is needed after reset.
// A new word is taken only when the sequencer is idle and the result register is free
// or being drained.
module multilevel_priority_queue
    import mlpq_pkg::*;
#(
    parameter int PRIORITY_SPAN = 8,
    parameter int LEVEL_DEPTH   = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // value_in[31:0], priority_in[36:32], zero pad
    input  logic [0:0]         s_tuser,   // mode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // value_out[31:0], priority_out[36:32], zero pad
    output logic [1:0]         m_tuser    // status
);

    localparam int NUM_LEVELS = 2 * PRIORITY_SPAN + 1;
    localparam int LW         = $clog2(NUM_LEVELS);
    localparam int HW         = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW         = $clog2(LEVEL_DEPTH + 1);
    localparam int ENTRIES    = NUM_LEVELS * LEVEL_DEPTH;
    localparam int AW         = $clog2(ENTRIES);
    localparam logic [AW-1:0] DEPTH_A = AW'(LEVEL_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(LEVEL_DEPTH);

    mlpq_state_t state_reg, state_next;

    logic               mode_reg, mode_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [NUM_LEVELS-1:0] mask_reg, mask_next;

    logic               m_tvalid_reg, m_tvalid_next;
    mlpq_status_t       status_reg, status_next;
    logic [VALUE_W-1:0] value_out_reg, value_out_next;
    logic [PRIO_W-1:0]  prio_out_reg, prio_out_next;

    logic               accept;
    logic               in_mode;
    logic [VALUE_W-1:0] in_value;
    logic [PRIO_W-1:0]  in_prio;
    logic [LW-1:0]      ins_level;
    logic [LW-1:0]      low_level;
    logic               mask_any;
    logic [LW-1:0]      sel_level;
    logic               empty_remove;

    logic [HW-1:0]      rd_head;
    logic [CW-1:0]      rd_count;
    logic               lvl_wr_en;
    logic [HW-1:0]      lvl_wr_head;
    logic [CW-1:0]      lvl_wr_count;

    logic               level_full;
    logic [HW:0]        head_inc;
    logic [HW-1:0]      head_wrap;
    logic [CW:0]        slot_sum;
    logic [CW:0]        slot_idx;

    logic               ent_wr_en;
    logic               ent_rd_en;
    logic [AW-1:0]      ent_rd_addr;
    logic [AW-1:0]      ent_wr_addr;
    logic [VALUE_W-1:0] ent_rd_data;

    assign in_mode  = s_tuser[0];
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_prio  = s_tdata[VALUE_W+PRIO_W-1:VALUE_W];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        int p;
        p = int'($signed(in_prio));
        if (p < -PRIORITY_SPAN) begin
            p = -PRIORITY_SPAN;
        end
        if (p > PRIORITY_SPAN) begin
            p = PRIORITY_SPAN;
        end
        ins_level = LW'(p + PRIORITY_SPAN);
    end

    always_comb begin
        low_level = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                low_level = LW'(i);
            end
        end
    end

    assign mask_any     = |mask_reg;
    assign sel_level    = (in_mode == MODE_REMOVE) ? low_level : ins_level;
    assign empty_remove = (in_mode == MODE_REMOVE) && !mask_any;

    assign level_full = (rd_count == DEPTH_C);
    assign head_inc   = {1'b0, rd_head} + (HW+1)'(1);
    assign head_wrap  = (head_inc == (HW+1)'(LEVEL_DEPTH)) ? '0 : head_inc[HW-1:0];
    assign slot_sum   = (CW+1)'(rd_head) + (CW+1)'(rd_count);
    assign slot_idx   = (slot_sum >= (CW+1)'(LEVEL_DEPTH)) ?
                        slot_sum - (CW+1)'(LEVEL_DEPTH) : slot_sum;
    assign ent_wr_addr = base_reg + AW'(slot_idx);
    assign ent_rd_addr = base_reg + AW'(rd_head);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !empty_remove) begin
                    state_next = ST_META;
                end
            end
            ST_META: begin
                state_next = (mode_reg == MODE_REMOVE) ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        lvl_wr_en      = 1'b0;
        lvl_wr_head    = rd_head;
        lvl_wr_count   = rd_count;
        ent_wr_en      = 1'b0;
        ent_rd_en      = 1'b0;
        mask_next      = mask_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        prio_out_next  = prio_out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && empty_remove) begin
                    m_tvalid_next  = 1'b1;
                    status_next    = STATUS_EMPTY;
                    value_out_next = '0;
                    prio_out_next  = '0;
                end
            end
            ST_META: begin
                if (mode_reg == MODE_INSERT) begin
                    m_tvalid_next  = 1'b1;
                    value_out_next = '0;
                    prio_out_next  = '0;
                    if (level_full) begin
                        status_next = STATUS_FULL;
                    end else begin
                        status_next           = STATUS_INSERTED;
                        ent_wr_en             = 1'b1;
                        lvl_wr_en             = 1'b1;
                        lvl_wr_count          = rd_count + CW'(1);
                        mask_next[level_reg]  = 1'b1;
                    end
                end else begin
                    ent_rd_en    = 1'b1;
                    lvl_wr_en    = 1'b1;
                    lvl_wr_head  = head_wrap;
                    lvl_wr_count = rd_count - CW'(1);
                    if (rd_count == CW'(1)) begin
                        mask_next[level_reg] = 1'b0;
                    end
                end
            end
            ST_READ: begin
                m_tvalid_next  = 1'b1;
                status_next    = STATUS_REMOVED;
                value_out_next = ent_rd_data;
                prio_out_next  = PRIO_W'(int'(level_reg) - PRIORITY_SPAN);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        value_next = value_reg;
        level_next = level_reg;
        base_next  = base_reg;
        if (accept) begin
            mode_next  = in_mode;
            value_next = in_value;
            level_next = sel_level;
            base_next  = AW'(sel_level) * DEPTH_A;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        value_reg     <= value_next;
        level_reg     <= level_next;
        base_reg      <= base_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        prio_out_reg  <= prio_out_next;
    end

    mlpq_level_mem #(
        .LEVELS (NUM_LEVELS),
        .LW     (LW),
        .HW     (HW),
        .CW     (CW)
    ) u_level_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (sel_level),
        .rd_head  (rd_head),
        .rd_count (rd_count),
        .wr_en    (lvl_wr_en),
        .wr_addr  (level_reg),
        .wr_head  (lvl_wr_head),
        .wr_count (lvl_wr_count)
    );

    mlpq_entry_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_entry_mem (
        .aclk    (aclk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (value_reg),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(TDATA_W-VALUE_W-PRIO_W){1'b0}}, prio_out_reg, value_out_reg};

endmodule

/* rtl/mlpq_entry_mem.sv */
// Data word storage of the multilevel priority queue: one ring of words per level.
// Single write port and one read port with registered read data; no reset.
// Uses mlpq_pkg for the word width.
module mlpq_entry_mem
    import mlpq_pkg::*;
#(
    parameter int DEPTH = 68,
    parameter int AW    = 7
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mlpq_level_mem.sv */
// Per-level bookkeeping of the multilevel priority queue: ring head and fill count.
// A memory with registered read data; one valid bit per level makes an unwritten level
// read as empty with its head at zero. Uses mlpq_pkg.
module mlpq_level_mem
    import mlpq_pkg::*;
#(
    parameter int LEVELS = 17,
    parameter int LW     = 5,
    parameter int HW     = 2,
    parameter int CW     = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [LW-1:0] rd_addr,
    output logic [HW-1:0] rd_head,
    output logic [CW-1:0] rd_count,
    input  logic          wr_en,
    input  logic [LW-1:0] wr_addr,
    input  logic [HW-1:0] wr_head,
    input  logic [CW-1:0] wr_count
);

    logic [HW+CW-1:0] mem [LEVELS];
    logic [LEVELS-1:0] valid_reg;
    logic [LEVELS-1:0] valid_next;
    logic [HW+CW-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_head, wr_count};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_head  = rd_valid_reg ? rd_data_reg[HW+CW-1:CW] : '0;
    assign rd_count = rd_valid_reg ? rd_data_reg[CW-1:0] : '0;

endmodule

/* test/tb_multilevel_priority_queue.sv */
// Testbench for multilevel_priority_queue: random and directed insert and remove words
// with a cycle-free predictor of the per-level rings and an in-order result scoreboard.
// Depends on mlpq_pkg and the RTL of the block; reads no files.
module tb_multilevel_priority_queue;
    import mlpq_pkg::*;

    localparam int SPAN       = 8;
    localparam int DEPTH      = 4;
    localparam int LEVELS     = 2 * SPAN + 1;
    localparam int RANDOM_OPS = 1575;
    localparam int CHUNK      = 100;

    typedef struct {
        logic        mode;
        logic [31:0] value;
        logic [4:0]  prio;
        int          phase;
    } queue_op_t;

    typedef struct {
        mlpq_status_t status;
        logic [31:0]  value;
        logic [4:0]   prio;
    } queue_resp_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    queue_op_t   op_feed[$];
    queue_resp_t pending_responses[$];
    queue_op_t   op_on_bus;
    int          rx_stall_pct   = 0;
    int          mismatch_count = 0;

    logic [31:0] level_words [LEVELS][DEPTH];
    int          level_head  [LEVELS];
    int          level_fill  [LEVELS];

    multilevel_priority_queue #(
        .PRIORITY_SPAN(SPAN),
        .LEVEL_DEPTH  (DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int tx_idle_pct(input int phase);
        return (phase == 1) ? 72 : ((phase == 3) ? 7 : 0);
    endfunction

    function automatic int rx_stall_for(input int phase);
        return (phase == 2) ? 72 : ((phase == 3) ? 7 : 0);
    endfunction

    function automatic queue_op_t make_op(input logic mode, input logic [31:0] value,
                                          input logic [4:0] prio, input int phase);
        queue_op_t op;
        op.mode  = mode;
        op.value = value;
        op.prio  = prio;
        op.phase = phase;
        return op;
    endfunction

    // Applies one word to the level rings and queues the response the block must give.
    function automatic void serve_queue_op(input queue_op_t op);
        queue_resp_t r;
        int          p;
        int          lvl;
        int          slot;
        r.status = STATUS_INSERTED;
        r.value  = '0;
        r.prio   = '0;
        if (op.mode == MODE_INSERT) begin
            p = int'($signed(op.prio));
            if (p < -SPAN) p = -SPAN;
            if (p > SPAN) p = SPAN;
            lvl = p + SPAN;
            if (level_fill[lvl] >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                slot = (level_head[lvl] + level_fill[lvl]) % DEPTH;
                level_words[lvl][slot] = op.value;
                level_fill[lvl]++;
            end
        end else begin
            r.status = STATUS_EMPTY;
            lvl = 0;
            while (lvl < LEVELS && level_fill[lvl] == 0) lvl++;
            if (lvl < LEVELS) begin
                r.status = STATUS_REMOVED;
                r.value  = level_words[lvl][level_head[lvl]];
                p        = lvl - SPAN;
                r.prio   = p[4:0];
                level_head[lvl] = (level_head[lvl] + 1) % DEPTH;
                level_fill[lvl]--;
            end
        end
        pending_responses.push_back(r);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at %0t: got %h, expected %h", field, $time, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : feed_driver
        queue_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                serve_queue_op(op_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (op_feed.size() > 0 &&
                        $urandom_range(99) >= tx_idle_pct(op_feed[0].phase)) begin
                    nxt          = op_feed.pop_front();
                    op_on_bus    = nxt;
                    rx_stall_pct = rx_stall_for(nxt.phase);
                    s_tvalid     <= 1'b1;
                    s_tdata      <= {3'b000, nxt.prio, nxt.value};
                    s_tuser      <= nxt.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        queue_resp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_responses.size() == 0) begin
                    report_mismatch("unexpected result word", m_tdata[31:0], '0);
                end else begin
                    want = pending_responses.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("value", m_tdata[31:0], want.value);
                    if (m_tdata[36:32] !== want.prio)
                        report_mismatch("priority", 32'(m_tdata[36:32]), 32'(want.prio));
                    if (m_tdata[TDATA_W-1:37] !== '0)
                        report_mismatch("tdata padding", 32'(m_tdata[TDATA_W-1:37]), '0);
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : stimulus
        int         i;
        int         k;
        int         chunk;
        int         phase;
        int         insert_pct;
        int         hot_base;
        int         t;
        logic [4:0] pr;
        logic       mode;

        for (i = 0; i < LEVELS; i++) begin
            level_head[i] = 0;
            level_fill[i] = 0;
        end

        // Directed words: empty remove, saturated and extreme priorities, a full level.
        op_feed.push_back(make_op(MODE_REMOVE, $urandom, 5'($urandom_range(31)), 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'h7FFF_FFFF, 5'b10000, 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'h8000_0000, 5'b01111, 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'h0000_0000, 5'b11000, 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'hFFFF_FFFF, 5'b01000, 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'hA5A5_A5A5, 5'b00000, 0));
        for (k = 0; k < DEPTH + 1; k++)
            op_feed.push_back(make_op(MODE_INSERT, $urandom, 5'b11011, 0));
        op_feed.push_back(make_op(MODE_INSERT, 32'h5A5A_5A5A, 5'b10111, 0));
        for (k = 0; k < 11; k++)
            op_feed.push_back(make_op(MODE_REMOVE, $urandom, 5'($urandom_range(31)), 0));

        // Random words in chunks; each chunk favors a few adjacent levels so rings fill,
        // overflow, drain and wrap, with the insert share varying from chunk to chunk.
        insert_pct = 50;
        hot_base   = 0;
        phase      = 0;
        for (i = 0; i < RANDOM_OPS; i++) begin
            if (i % CHUNK == 0) begin
                chunk      = i / CHUNK;
                phase      = chunk % 4;
                insert_pct = (chunk % 3 == 0) ? 75 : ((chunk % 3 == 1) ? 50 : 30);
                hot_base   = int'($urandom_range(LEVELS - 3));
            end
            if ($urandom_range(99) < 70) begin
                t  = hot_base + int'($urandom_range(2)) - SPAN;
                pr = t[4:0];
            end else begin
                pr = 5'($urandom_range(31));
            end
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            op_feed.push_back(make_op(mode, $urandom, pr, phase));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (op_feed.size() > 0 || s_tvalid) @(posedge aclk);
        while (pending_responses.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
